@@ hdl/hta_pkg.sv @@
// handle table allocator package: sizes, handle and request codes
// no dependencies; imported by handle_table_allocator
package hta_pkg;

  localparam int FAST_HANDLES = 1024;
  localparam int SEGMENT_SIZE = 512;
  localparam int SEGMENTS     = 8;
  localparam int VALUE_WIDTH  = 64;

  localparam int TOTAL    = FAST_HANDLES + SEGMENT_SIZE * SEGMENTS;
  localparam int HANDLE_W = 13;

  typedef logic [HANDLE_W-1:0] handle_t;

  // handles never reach all ones, so that pattern marks an empty list
  localparam handle_t NO_HANDLE = '1;

  localparam logic [HANDLE_W:0] TOTAL_C   = (HANDLE_W+1)'(TOTAL);
  localparam logic [HANDLE_W:0] FAST_C    = (HANDLE_W+1)'(FAST_HANDLES);
  localparam handle_t           HW_RESET  = HANDLE_W'(FAST_HANDLES - 1);
  localparam handle_t           SEGMENT_C = HANDLE_W'(SEGMENT_SIZE);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ALLOC  = 2'd0;
  localparam kind_t KIND_LOOKUP = 2'd1;
  localparam kind_t KIND_FREE   = 2'd2;
  localparam kind_t KIND_COPY   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_ALLOC = 2'd2;

endpackage

@@ hdl/handle_table_allocator.sv @@
// handle table allocator top level: value store, allocated flags and free links
// depends on hta_pkg and hta_ram
//
// usage
//   in_*  channel: one request per accepted item; in_tuser is the request kind
//         (allocate, look up, free, copy), in_tdata carries handle and value
//   out_* channel: exactly one result per request, in request order;
//         out_tuser is the status, out_tdata the granted handle, the stored
//         value and its zero flag
//   a request passes idle and exec: the accept cycle issues the reads of the value
//   ram (at the request handle) and of the link ram (at the stack top or queue
//   head), the next cycle evaluates, writes back and loads the output register;
//   the result is visible the cycle after that; no new request is accepted in
//   exec, only back in idle, as the reads of the rams are registered
//   after reset a clearing pass over all TOTAL (5120) entries wipes the allocated
//   flags; in_tready stays low meanwhile
//   a stalled receiver holds the output register; the next request is taken
//   only once the pending result has left or is leaving
module handle_table_allocator
  import hta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // handle [12:0], value [76:13], zero fill [79:77]
  input  logic [1:0]  in_tuser,   // kind [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // new_handle [12:0], stored_value [76:13],
                                  // value_is_zero [77], zero fill [79:78]
  output logic [1:0]  out_tuser   // status [1:0]
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  localparam int VAL_RAM_W = VALUE_WIDTH + 1;

  // request fields
  handle_t                in_handle;
  logic [VALUE_WIDTH-1:0] in_value;
  assign in_handle = in_tdata[12:0];
  assign in_value  = in_tdata[13 +: VALUE_WIDTH];

  logic [1:0] state_r, state_nxt;
  handle_t    clr_cnt_r, clr_cnt_nxt;

  // captured request
  kind_t                  kind_r;
  handle_t                handle_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic                   hrange_r;

  // free list pointers
  handle_t stack_top_r, stack_top_nxt;
  handle_t queue_head_r, queue_head_nxt;
  handle_t queue_tail_r, queue_tail_nxt;
  handle_t fresh_next_r, fresh_next_nxt;
  handle_t high_water_r, high_water_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  handle_t                out_handle_r, out_handle_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                   out_zero_r, out_zero_nxt;

  logic accept;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // ram ports
  logic                 val_we;
  handle_t              val_waddr, val_raddr;
  logic [VAL_RAM_W-1:0] val_wdata, val_rdata;
  logic                 link_we;
  handle_t              link_waddr, link_raddr, link_wdata, link_rdata;

  // out of range handles read entry zero; the range flag rejects them later
  assign val_raddr  = ({1'b0, in_handle} < TOTAL_C) ? in_handle : '0;
  assign link_raddr = (stack_top_r != NO_HANDLE)  ? stack_top_r :
                      (queue_head_r != NO_HANDLE) ? queue_head_r : '0;

  hta_ram #(.WIDTH(VAL_RAM_W), .DEPTH(TOTAL)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  hta_ram #(.WIDTH(HANDLE_W), .DEPTH(TOTAL)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // evaluation of the captured request against the read data
  logic [VALUE_WIDTH-1:0] rd_value;
  logic                   rd_alloc;
  logic                   h_ok;
  logic                   g_ok;
  handle_t                g;
  handle_t                g_stack, g_head, g_fresh, g_hw;
  logic                   do_grant;
  logic [VALUE_WIDTH-1:0] g_value;

  assign rd_value = val_rdata[VALUE_WIDTH-1:0];
  assign rd_alloc = val_rdata[VALUE_WIDTH];
  assign h_ok     = hrange_r && rd_alloc;

  // candidate grant in priority order: stack, fresh range, queue, new segment
  always_comb begin
    g       = '0;
    g_ok    = 1'b1;
    g_stack = stack_top_r;
    g_head  = queue_head_r;
    g_fresh = fresh_next_r;
    g_hw    = high_water_r;
    if (stack_top_r != NO_HANDLE) begin
      g       = stack_top_r;
      g_stack = link_rdata;
    end else if (fresh_next_r <= high_water_r) begin
      g       = fresh_next_r;
      g_fresh = fresh_next_r + 1'b1;
    end else if (queue_head_r != NO_HANDLE) begin
      g      = queue_head_r;
      g_head = (queue_head_r == queue_tail_r) ? NO_HANDLE : link_rdata;
    end else if (({1'b0, high_water_r} + 1'b1) < TOTAL_C) begin
      g       = high_water_r + 1'b1;
      g_fresh = high_water_r + 2'd2;
      g_hw    = high_water_r + SEGMENT_C;
    end else begin
      g_ok = 1'b0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    stack_top_nxt  = stack_top_r;
    queue_head_nxt = queue_head_r;
    queue_tail_nxt = queue_tail_r;
    fresh_next_nxt = fresh_next_r;
    high_water_nxt = high_water_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_value_nxt  = out_value_r;
    out_zero_nxt   = out_zero_r;
    val_we         = 1'b0;
    val_waddr      = clr_cnt_r;
    val_wdata      = '0;
    link_we        = 1'b0;
    link_waddr     = handle_r;
    link_wdata     = stack_top_r;
    do_grant       = 1'b0;
    g_value        = value_r;

    unique case (state_r)
      S_CLEAR: begin
        // wipe allocated flags one entry a cycle
        val_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if ({1'b0, clr_cnt_r} == TOTAL_C - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_handle_nxt = '0;
        out_value_nxt  = '0;
        out_zero_nxt   = 1'b0;
        if (kind_r == KIND_ALLOC) begin
          do_grant = 1'b1;
        end else if (!h_ok) begin
          out_status_nxt = ST_NOT_ALLOC;
        end else begin
          case (kind_r) inside
            KIND_LOOKUP, KIND_COPY: begin
              out_value_nxt = rd_value;
              out_zero_nxt  = (rd_value == '0);
              g_value       = rd_value;
              do_grant      = (kind_r == KIND_COPY);
            end
            default: begin
              // release: clear flag, push fast handles, queue the others
              val_we    = 1'b1;
              val_waddr = handle_r;
              link_we   = 1'b1;
              if ({1'b0, handle_r} < FAST_C) begin
                link_waddr    = handle_r;
                link_wdata    = stack_top_r;
                stack_top_nxt = handle_r;
              end else begin
                link_waddr     = queue_tail_r;
                link_wdata     = handle_r;
                link_we        = (queue_head_r != NO_HANDLE);
                queue_tail_nxt = handle_r;
                if (queue_head_r == NO_HANDLE) begin
                  queue_head_nxt = handle_r;
                end
              end
            end
          endcase
        end
        if (do_grant) begin
          if (g_ok) begin
            out_handle_nxt = g;
            val_we         = 1'b1;
            val_waddr      = g;
            val_wdata      = {1'b1, g_value};
            stack_top_nxt  = g_stack;
            queue_head_nxt = g_head;
            fresh_next_nxt = g_fresh;
            high_water_nxt = g_hw;
          end else begin
            out_status_nxt = ST_FULL;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      stack_top_r  <= NO_HANDLE;
      queue_head_r <= NO_HANDLE;
      queue_tail_r <= '0;
      fresh_next_r <= '0;
      high_water_r <= HW_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      stack_top_r  <= stack_top_nxt;
      queue_head_r <= queue_head_nxt;
      queue_tail_r <= queue_tail_nxt;
      fresh_next_r <= fresh_next_nxt;
      high_water_r <= high_water_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_tuser;
      handle_r <= in_handle;
      value_r  <= in_value;
      hrange_r <= ({1'b0, in_handle} < TOTAL_C);
    end
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_value_r  <= out_value_nxt;
    out_zero_r   <= out_zero_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_zero_r, 64'(out_value_r), out_handle_r};

endmodule

@@ hdl/hta_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies; used by handle_table_allocator
module hta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sim/handle_table_allocator_test.sv @@
// self-checking testbench for handle_table_allocator: directed table, then random requests
// depends on hta_pkg and the handle_table_allocator rtl; no files or arguments needed
module handle_table_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hta_pkg::*;

  // run shape
  localparam int STALL_LIMIT     = 20000;  // outlasts the clearing pass over all 5120 entries after reset
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER  = 300;    // results seen before the long receiver stall
  localparam int MIXED_REQUESTS  = 150;
  localparam int FILL_REQUESTS   = 1050;
  localparam int DRAIN_REQUESTS  = 125;
  localparam int DIRECTED_ROWS   = 25;

  // list pointers carry one extra bit so all ones marks an empty list
  localparam logic [HANDLE_W:0] LIST_EMPTY = '1;
  localparam logic [63:0]       ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    status_t     status;
    handle_t     new_handle;
    logic [63:0] stored_value;
    logic        value_is_zero;
  } response_t;

  // one directed request; when pinned is set the response is typed in by hand
  typedef struct packed {
    kind_t       kind;
    handle_t     handle;
    logic [63:0] value;
    logic        pinned;
    response_t   want;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // handle [12:0], value [76:13], zero fill [79:77]
  logic [1:0]  in_tuser;   // kind [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // new_handle [12:0], stored_value [76:13],
                           // value_is_zero [77], zero fill [79:78]
  logic [1:0]  out_tuser;  // status [1:0]

  handle_table_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the handle table
  // ---------------------------------------------------------------------------
  logic [63:0]       shadow_value [TOTAL];
  bit                shadow_live  [TOTAL];
  logic [HANDLE_W:0] shadow_link  [TOTAL];
  logic [HANDLE_W:0] lifo_top;     // most recently freed fast handle
  logic [HANDLE_W:0] fifo_head;    // oldest freed overflow handle
  handle_t           fifo_tail;
  handle_t           fresh_ptr;    // next never-used handle
  handle_t           fresh_limit;  // last handle of the open range

  // responses still owed by the block, oldest first
  response_t pending_responses[$];
  // handles the shadow table holds as allocated, used to aim requests
  handle_t   live_handles[$];

  int error_count;
  int results_seen;
  int burst_left;
  int full_hits;
  int not_alloc_hits;
  int peak_live;
  int kind_count [4];
  bit hold_off_done;

  function automatic void clear_shadow_table();
    for (int i = 0; i < TOTAL; i++) begin
      shadow_live[i] = 1'b0;
    end
    lifo_top    = LIST_EMPTY;
    fifo_head   = LIST_EMPTY;
    fifo_tail   = '0;
    fresh_ptr   = '0;
    fresh_limit = HW_RESET;
  endfunction

  // free order: fast stack, never-used range, overflow queue, then a new segment
  function automatic bit grant_handle(input logic [63:0] v, output handle_t h);
    h = '0;
    if (lifo_top != LIST_EMPTY) begin
      h        = lifo_top[HANDLE_W-1:0];
      lifo_top = shadow_link[h];
    end else if (fresh_ptr <= fresh_limit) begin
      h         = fresh_ptr;
      fresh_ptr = fresh_ptr + 1'b1;
    end else if (fifo_head != LIST_EMPTY) begin
      h         = fifo_head[HANDLE_W-1:0];
      fifo_head = (h == fifo_tail) ? LIST_EMPTY : shadow_link[h];
    end else if (int'(fresh_limit) + 1 < TOTAL) begin
      // open the next segment and hand out its first entry at once
      h           = fresh_limit + 1'b1;
      fresh_ptr   = h + 1'b1;
      fresh_limit = fresh_limit + SEGMENT_C;
    end else begin
      return 1'b0;
    end
    shadow_value[h] = v;
    shadow_live[h]  = 1'b1;
    return 1'b1;
  endfunction

  function automatic void release_handle(handle_t h);
    shadow_value[h] = '0;
    shadow_live[h]  = 1'b0;
    if (int'(h) < FAST_HANDLES) begin
      shadow_link[h] = lifo_top;
      lifo_top       = {1'b0, h};
    end else begin
      shadow_link[h] = LIST_EMPTY;
      if (fifo_head == LIST_EMPTY) begin
        fifo_head = {1'b0, h};
      end else begin
        shadow_link[fifo_tail] = {1'b0, h};
      end
      fifo_tail = h;
    end
  endfunction

  // response to one request, updating the shadow table as the block would
  function automatic response_t table_response(kind_t kind, handle_t h, logic [63:0] v);
    response_t r;
    handle_t   g;
    r = '0;
    if (kind == KIND_ALLOC) begin
      if (grant_handle(v, g)) begin
        r.new_handle = g;
      end else begin
        r.status = ST_FULL;
      end
    end else if (int'(h) >= TOTAL || !shadow_live[h]) begin
      r.status = ST_NOT_ALLOC;
    end else begin
      case (kind)
        KIND_LOOKUP: begin
          r.stored_value  = shadow_value[h];
          r.value_is_zero = (shadow_value[h] == '0);
        end
        KIND_FREE: begin
          release_handle(h);
        end
        default: begin
          // copy: read the entry, then allocate its value; full leaves state alone
          r.stored_value  = shadow_value[h];
          r.value_is_zero = (shadow_value[h] == '0);
          if (grant_handle(shadow_value[h], g)) begin
            r.new_handle = g;
          end else begin
            r.status = ST_FULL;
          end
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table, walked from the reset state
  // ---------------------------------------------------------------------------
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // first grants come from the never-used range in ascending order
    '{KIND_ALLOC,  13'd0,    64'd0,                 1'b1, '{ST_OK, 13'd0, 64'd0, 1'b0}},
    '{KIND_ALLOC,  13'h1FFF, ALL_ONES,              1'b1, '{ST_OK, 13'd1, 64'd0, 1'b0}},
    // zero flag set and clear
    '{KIND_LOOKUP, 13'd0,    ALL_ONES,              1'b1, '{ST_OK, 13'd0, 64'd0, 1'b1}},
    '{KIND_LOOKUP, 13'd1,    64'd0,                 1'b1, '{ST_OK, 13'd0, ALL_ONES, 1'b0}},
    // handles never allocated or beyond the table
    '{KIND_LOOKUP, 13'd2,    64'd0,                 1'b1, '{ST_NOT_ALLOC, 13'd0, 64'd0, 1'b0}},
    '{KIND_LOOKUP, 13'd5119, 64'd0,                 1'b1, '{ST_NOT_ALLOC, 13'd0, 64'd0, 1'b0}},
    '{KIND_LOOKUP, 13'd5120, 64'd0,                 1'b1, '{ST_NOT_ALLOC, 13'd0, 64'd0, 1'b0}},
    '{KIND_LOOKUP, 13'h1FFF, 64'd0,                 1'b1, '{ST_NOT_ALLOC, 13'd0, 64'd0, 1'b0}},
    '{KIND_FREE,   13'h1FFF, ALL_ONES,              1'b1, '{ST_NOT_ALLOC, 13'd0, 64'd0, 1'b0}},
    '{KIND_COPY,   13'd6000, 64'd0,                 1'b1, '{ST_NOT_ALLOC, 13'd0, 64'd0, 1'b0}},
    // copy grants the next fresh handle and reports the source value
    '{KIND_COPY,   13'd1,    64'd0,                 1'b1, '{ST_OK, 13'd2, ALL_ONES, 1'b0}},
    '{KIND_FREE,   13'd0,    64'd0,                 1'b1, '{ST_OK, 13'd0, 64'd0, 1'b0}},
    // freed handle reads as unallocated, double free is refused
    '{KIND_LOOKUP, 13'd0,    64'd0,                 1'b1, '{ST_NOT_ALLOC, 13'd0, 64'd0, 1'b0}},
    '{KIND_FREE,   13'd0,    64'd0,                 1'b1, '{ST_NOT_ALLOC, 13'd0, 64'd0, 1'b0}},
    // freed fast handle is reused ahead of the fresh range
    '{KIND_ALLOC,  13'd0,    64'h0123_4567_89AB_CDEF, 1'b1, '{ST_OK, 13'd0, 64'd0, 1'b0}},
    '{KIND_COPY,   13'd0,    64'd0,                 1'b0, '0},
    // stack order: last freed comes back first
    '{KIND_FREE,   13'd2,    64'd0,                 1'b0, '0},
    '{KIND_FREE,   13'd3,    64'd0,                 1'b0, '0},
    '{KIND_ALLOC,  13'd0,    64'h5555_5555_5555_5555, 1'b0, '0},
    '{KIND_ALLOC,  13'd0,    64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{KIND_COPY,   13'd4,    64'd0,                 1'b1, '{ST_NOT_ALLOC, 13'd0, 64'd0, 1'b0}},
    '{KIND_FREE,   13'd1,    64'd0,                 1'b0, '0},
    '{KIND_ALLOC,  13'd0,    64'h8000_0000_0000_0000, 1'b0, '0},
    '{KIND_LOOKUP, 13'd1,    64'd0,                 1'b0, '0},
    '{KIND_COPY,   13'd2,    64'd0,                 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request, wait for it to be taken and record the response owed;
  // always called and left just after a rising edge
  task automatic send_request(kind_t kind, handle_t h, logic [63:0] v,
                              bit pinned, response_t want);
    response_t r;
    int        pos[$];
    // bursts of random length, random gaps between them
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, v, h};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    kind_count[kind]++;

    r = table_response(kind, h, v);
    if (r.status == ST_FULL) full_hits++;
    if (r.status == ST_NOT_ALLOC) not_alloc_hits++;
    if (r.status == ST_OK && (kind == KIND_ALLOC || kind == KIND_COPY)) begin
      live_handles.push_back(r.new_handle);
    end
    if (r.status == ST_OK && kind == KIND_FREE) begin
      pos = live_handles.find_first_index(x) with (x == h);
      if (pos.size() != 0) live_handles.delete(pos[0]);
    end
    if (live_handles.size() > peak_live) peak_live = live_handles.size();
    pending_responses.push_back(pinned ? want : r);
  endtask

  // one random request; weights in percent, the rest is noise on any kind and handle
  task automatic random_request(int w_alloc, int w_free, int w_lookup, int w_copy);
    int          roll;
    kind_t       kind;
    handle_t     h;
    logic [63:0] v;
    roll = $urandom_range(0, 99);
    v    = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 1) ? '0 : ALL_ONES;
    h = (live_handles.size() != 0)
        ? live_handles[$urandom_range(0, live_handles.size() - 1)]
        : handle_t'($urandom_range(0, 8191));
    if (roll >= w_alloc + w_free + w_lookup + w_copy) begin
      kind = kind_t'($urandom_range(0, 3));
      h    = handle_t'($urandom_range(0, 8191));
    end else if (roll < w_alloc || live_handles.size() == 0) begin
      kind = KIND_ALLOC;
      h    = handle_t'($urandom_range(0, 8191));
    end else if (roll < w_alloc + w_free) begin
      kind = KIND_FREE;
    end else if (roll < w_alloc + w_free + w_lookup) begin
      kind = KIND_LOOKUP;
    end else begin
      kind = KIND_COPY;
    end
    send_request(kind, h, v, 1'b0, '0);
  endtask

  initial begin : stimulus
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = KIND_ALLOC;
    in_tdata   = '0;
    burst_left = 0;
    clear_shadow_table();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows; in_tready stays low through the clearing pass
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(directed_rows[i].kind, directed_rows[i].handle, directed_rows[i].value,
                   directed_rows[i].pinned, directed_rows[i].want);
    end

    // balanced mix: stack reuse, copies, lookups and stray handles
    repeat (MIXED_REQUESTS) random_request(35, 25, 15, 15);

    // almost only allocations, enough to use up the fast handles and open
    // the first overflow segment
    repeat (FILL_REQUESTS) random_request(95, 0, 1, 3);

    // heavy freeing, then reuse of the freed handles
    repeat (DRAIN_REQUESTS) random_request(20, 50, 10, 15);

    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("run covered %0d requests (%0d allocate, %0d look up, %0d free, %0d copy)",
             kind_count[KIND_ALLOC] + kind_count[KIND_LOOKUP] + kind_count[KIND_FREE] +
             kind_count[KIND_COPY], kind_count[KIND_ALLOC], kind_count[KIND_LOOKUP],
             kind_count[KIND_FREE], kind_count[KIND_COPY]);
    $display("%0d table-full and %0d unallocated-handle responses, up to %0d handles in use",
             full_hits, not_alloc_hits, peak_live);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver changes its pattern at random intervals; once, a long hold-off
  // while requests keep coming, so the block fills and drops in_tready
  initial begin : receiver
    int mode;
    int span;
    out_tready    = 1'b0;
    hold_off_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!hold_off_done && results_seen >= HOLD_OFF_AFTER) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 80);
        for (int phase = 0; phase < span; phase++) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            2:       out_tready <= ($urandom_range(0, 7) != 0);
            default: out_tready <= (phase % 4 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  response_t oldest;

  // compare each result with the oldest response owed
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_responses.size() == 0) begin
        $error("result with no request outstanding: status %0d handle %0d",
               out_tuser, out_tdata[12:0]);
        error_count++;
      end else begin
        oldest = pending_responses.pop_front();
        if (out_tuser !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_tuser);
          error_count++;
        end
        if (out_tdata[12:0] !== oldest.new_handle) begin
          $error("new_handle: expected %0d, got %0d", oldest.new_handle, out_tdata[12:0]);
          error_count++;
        end
        if (out_tdata[76:13] !== oldest.stored_value) begin
          $error("stored_value: expected %h, got %h", oldest.stored_value, out_tdata[76:13]);
          error_count++;
        end
        if (out_tdata[77] !== oldest.value_is_zero) begin
          $error("value_is_zero: expected %0d, got %0d", oldest.value_is_zero, out_tdata[77]);
          error_count++;
        end
      end
    end
  end

  // watchdog: too long with nothing moving on either channel ends the run
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no request or result moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_responses.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
hdl/hta_pkg.sv
hdl/hta_ram.sv
hdl/handle_table_allocator.sv
sim/handle_table_allocator_test.sv
